/* sv/sdcd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdcd_pkg
// Shared widths, constants, stage payload types and the day-offset table
// for the serial-day to calendar-date pipeline.
// ----------------------------------------------------------------------------
package sdcd_pkg;

    // Field widths
    localparam int SERIAL_W = 22;
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;

    // Internal widths (set by the value ranges of each intermediate)
    localparam int JDN_W   = 23;   // shifted day number, below 2^23
    localparam int CENT_W  = 8;    // century count, at most 182
    localparam int DOC_W   = 16;   // day within century, at most 36525
    localparam int YIC_W   = 7;    // year within century, at most 100
    localparam int DOY_W   = 10;   // day within year plus 31, at most 397
    localparam int MIX_W   = 4;    // month index, at most 12
    localparam int OFS_W   = 9;    // day offset table entry

    // Front-end constants
    localparam logic [JDN_W-1:0] BASE_1904_OFS = JDN_W'(1462);
    localparam logic [JDN_W-1:0] LEAP_SERIAL   = JDN_W'(60);
    localparam logic [JDN_W-1:0] JDN_OFS       = JDN_W'(68569 + 2415019);

    // Fictitious leap day 29 Feb 1900
    localparam logic [YEAR_W-1:0]  LEAP_YEAR  = YEAR_W'(1900);
    localparam logic [MONTH_W-1:0] LEAP_MONTH = MONTH_W'(2);
    localparam logic [DAY_W-1:0]   LEAP_DAY   = DAY_W'(29);

    // floor(x*4/146097) as (x*CENT_MUL) >> CENT_SHIFT, exact for x < 2^23
    localparam int CENT_SHIFT = 41;
    localparam int CENT_MUL_W = 26;
    localparam logic [CENT_MUL_W-1:0] CENT_MUL =
        CENT_MUL_W'(((64'd4 << CENT_SHIFT) + 64'd146096) / 64'd146097);
    localparam int CENT_PROD_W = JDN_W + CENT_MUL_W;
    localparam int CENT_DAYS_W = 25;
    localparam logic [CENT_DAYS_W-1:0] CENT_DAYS = CENT_DAYS_W'(146097);

    // floor(x*4000/1461001) as (x*YEAR_MUL) >> YEAR_SHIFT, exact for x < 2^16
    localparam int YEAR_SHIFT = 37;
    localparam int YEAR_MUL_W = 29;
    localparam logic [YEAR_MUL_W-1:0] YEAR_MUL =
        YEAR_MUL_W'(((64'd4000 << YEAR_SHIFT) + 64'd1461000) / 64'd1461001);
    localparam int YEAR_PROD_W = DOC_W + YEAR_MUL_W;
    localparam int QYEAR_W = 18;
    localparam logic [QYEAR_W-1:0] QYEAR_DAYS = QYEAR_W'(1461);
    localparam logic [DOC_W-1:0]   MONTH_BIAS = DOC_W'(31);
    localparam logic [YEAR_W-1:0]  CENT_SCALE = YEAR_W'(100);
    localparam logic [YEAR_W-1:0]  CENT_BIAS  = YEAR_W'(49);

    // floor(x*80/2447) as (x*MONTH_MUL) >> MONTH_SHIFT, exact for x < 2^10
    localparam int MONTH_SHIFT = 22;
    localparam int MONTH_MUL_W = 18;
    localparam logic [MONTH_MUL_W-1:0] MONTH_MUL =
        MONTH_MUL_W'(((64'd80 << MONTH_SHIFT) + 64'd2446) / 64'd2447);
    localparam int MONTH_PROD_W = DOY_W + MONTH_MUL_W;
    localparam logic [MIX_W-1:0] MIX_WRAP   = MIX_W'(11);
    localparam logic [MIX_W-1:0] MIX_START  = MIX_W'(2);
    localparam logic [MIX_W-1:0] MIX_YEAR   = MIX_W'(12);

    // Payload after the century stages
    typedef struct packed {
        logic              leap;
        logic [CENT_W-1:0] cent;
        logic [DOC_W-1:0]  doc;
    } cent_item_t;

    // Payload after the year stages
    typedef struct packed {
        logic              leap;
        logic [DOY_W-1:0]  doy;
        logic [YEAR_W-1:0] year_base;
    } year_item_t;

    // floor(2447*j/80), days before month index j
    function automatic logic [OFS_W-1:0] day_offset(input logic [MIX_W-1:0] j);
        logic [OFS_W-1:0] ofs;
        unique case (j)
            4'd0:    ofs = 9'd0;
            4'd1:    ofs = 9'd30;
            4'd2:    ofs = 9'd61;
            4'd3:    ofs = 9'd91;
            4'd4:    ofs = 9'd122;
            4'd5:    ofs = 9'd152;
            4'd6:    ofs = 9'd183;
            4'd7:    ofs = 9'd214;
            4'd8:    ofs = 9'd244;
            4'd9:    ofs = 9'd275;
            4'd10:   ofs = 9'd305;
            4'd11:   ofs = 9'd336;
            4'd12:   ofs = 9'd367;
            4'd13:   ofs = 9'd397;
            4'd14:   ofs = 9'd428;
            default: ofs = 9'd458;
        endcase
        return ofs;
    endfunction

endpackage

/* sv/sdcd_cent.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdcd_cent
// Stages 1-3: base/leap adjust, century quotient, day within century.
// ----------------------------------------------------------------------------
module sdcd_cent (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          calendar_mode,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [sdcd_pkg::SERIAL_W-1:0] serial_day,
    output logic                          out_valid,
    input  logic                          out_ready,
    output sdcd_pkg::cent_item_t          out_item
);

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s1_ready, s2_ready, s3_ready;

    logic [sdcd_pkg::JDN_W-1:0] v_base, v_adj;
    logic                       s1_leap_next, s1_leap_reg;
    logic [sdcd_pkg::JDN_W-1:0] s1_l0_next, s1_l0_reg;

    logic [sdcd_pkg::CENT_PROD_W-1:0] cent_prod;
    logic [sdcd_pkg::CENT_W-1:0]      s2_cent_next, s2_cent_reg;
    logic [sdcd_pkg::JDN_W-1:0]       s2_l0_reg;
    logic                             s2_leap_reg;

    logic [sdcd_pkg::CENT_DAYS_W-1:0] cyc_days;
    logic [sdcd_pkg::JDN_W-1:0]       cyc_start;
    sdcd_pkg::cent_item_t             s3_item_next, s3_item_reg;

    // Ready chain: a stage loads when empty or when its successor moves
    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready) s1_valid_reg <= in_valid;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
            if (s3_ready) s3_valid_reg <= s2_valid_reg;
        end
    end

    // Stage 1: base select, leap-day detect, early-serial shift, day offset
    always_comb
    begin
        v_base = sdcd_pkg::JDN_W'(serial_day)
               + (calendar_mode ? sdcd_pkg::BASE_1904_OFS : '0);
        s1_leap_next = (v_base == sdcd_pkg::LEAP_SERIAL);
        v_adj = (v_base < sdcd_pkg::LEAP_SERIAL) ? v_base + 1'b1 : v_base;
        s1_l0_next = v_adj + sdcd_pkg::JDN_OFS;
    end

    // Stage 2: cycle count by reciprocal multiply
    assign cent_prod = sdcd_pkg::CENT_PROD_W'(s1_l0_reg)
                     * sdcd_pkg::CENT_PROD_W'(sdcd_pkg::CENT_MUL);
    assign s2_cent_next = cent_prod[sdcd_pkg::CENT_SHIFT +: sdcd_pkg::CENT_W];

    // Stage 3: remove whole cycles
    always_comb
    begin
        cyc_days  = sdcd_pkg::CENT_DAYS * sdcd_pkg::CENT_DAYS_W'(s2_cent_reg);
        cyc_start = sdcd_pkg::JDN_W'((cyc_days + sdcd_pkg::CENT_DAYS_W'(3)) >> 2);
        s3_item_next.leap = s2_leap_reg;
        s3_item_next.cent = s2_cent_reg;
        s3_item_next.doc  = sdcd_pkg::DOC_W'(s2_l0_reg - cyc_start);
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            s1_leap_reg <= s1_leap_next;
            s1_l0_reg   <= s1_l0_next;
        end
        if (s1_valid_reg && s2_ready)
        begin
            s2_cent_reg <= s2_cent_next;
            s2_l0_reg   <= s1_l0_reg;
            s2_leap_reg <= s1_leap_reg;
        end
        if (s2_valid_reg && s3_ready)
        begin
            s3_item_reg <= s3_item_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_item  = s3_item_reg;

endmodule

/* sv/sdcd_year.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdcd_year
// Stages 4-5: year within cycle, day within year, partial year number.
// ----------------------------------------------------------------------------
module sdcd_year (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sdcd_pkg::cent_item_t in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sdcd_pkg::year_item_t out_item
);

    logic s4_valid_reg, s5_valid_reg;
    logic s4_ready, s5_ready;

    logic [sdcd_pkg::YEAR_PROD_W-1:0] year_prod;
    logic [sdcd_pkg::YIC_W-1:0]       s4_yic_next, s4_yic_reg;
    sdcd_pkg::cent_item_t             s4_item_reg;

    logic [sdcd_pkg::QYEAR_W-1:0]     qyear_days;
    logic [sdcd_pkg::DOC_W-1:0]       year_start;
    sdcd_pkg::year_item_t             s5_item_next, s5_item_reg;

    assign s5_ready = !s5_valid_reg || out_ready;
    assign s4_ready = !s4_valid_reg || s5_ready;
    assign in_ready = s4_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (s4_ready) s4_valid_reg <= in_valid;
            if (s5_ready) s5_valid_reg <= s4_valid_reg;
        end
    end

    // Stage 4: year within cycle by reciprocal multiply
    assign year_prod = sdcd_pkg::YEAR_PROD_W'(in_item.doc + 1'b1)
                     * sdcd_pkg::YEAR_PROD_W'(sdcd_pkg::YEAR_MUL);
    assign s4_yic_next = year_prod[sdcd_pkg::YEAR_SHIFT +: sdcd_pkg::YIC_W];

    // Stage 5: day within year (March-based) and year before month carry
    always_comb
    begin
        qyear_days = sdcd_pkg::QYEAR_DAYS * sdcd_pkg::QYEAR_W'(s4_yic_reg);
        year_start = sdcd_pkg::DOC_W'(qyear_days >> 2);
        s5_item_next.leap = s4_item_reg.leap;
        s5_item_next.doy  = sdcd_pkg::DOY_W'(s4_item_reg.doc - year_start
                                             + sdcd_pkg::MONTH_BIAS);
        s5_item_next.year_base = sdcd_pkg::YEAR_W'(sdcd_pkg::CENT_SCALE
                                 * (sdcd_pkg::YEAR_W'(s4_item_reg.cent)
                                    - sdcd_pkg::CENT_BIAS))
                               + sdcd_pkg::YEAR_W'(s4_yic_reg);
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s4_ready)
        begin
            s4_yic_reg  <= s4_yic_next;
            s4_item_reg <= in_item;
        end
        if (s4_valid_reg && s5_ready)
        begin
            s5_item_reg <= s5_item_next;
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_item  = s5_item_reg;

endmodule

/* sv/sdcd_mday.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdcd_mday
// Stages 6-7: month index, then day, month, final year and leap override.
// ----------------------------------------------------------------------------
module sdcd_mday (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  sdcd_pkg::year_item_t         in_item,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [sdcd_pkg::YEAR_W-1:0]  year_out,
    output logic [sdcd_pkg::MONTH_W-1:0] month_out,
    output logic [sdcd_pkg::DAY_W-1:0]   day_out
);

    logic s6_valid_reg, s7_valid_reg;
    logic s6_ready, s7_ready;

    logic [sdcd_pkg::MONTH_PROD_W-1:0] month_prod;
    logic [sdcd_pkg::MIX_W-1:0]        s6_mix_next, s6_mix_reg;
    sdcd_pkg::year_item_t              s6_item_reg;

    logic                              wrap;
    logic [sdcd_pkg::DOY_W-1:0]        day_full;
    logic [sdcd_pkg::YEAR_W-1:0]       year_next, year_reg;
    logic [sdcd_pkg::MONTH_W-1:0]      month_next, month_reg;
    logic [sdcd_pkg::DAY_W-1:0]        day_next, day_reg;

    assign s7_ready = !s7_valid_reg || out_ready;
    assign s6_ready = !s6_valid_reg || s7_ready;
    assign in_ready = s6_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else
        begin
            if (s6_ready) s6_valid_reg <= in_valid;
            if (s7_ready) s7_valid_reg <= s6_valid_reg;
        end
    end

    // Stage 6: month index by reciprocal multiply
    assign month_prod = sdcd_pkg::MONTH_PROD_W'(in_item.doy)
                      * sdcd_pkg::MONTH_PROD_W'(sdcd_pkg::MONTH_MUL);
    assign s6_mix_next = month_prod[sdcd_pkg::MONTH_SHIFT +: sdcd_pkg::MIX_W];

    // Stage 7: calendar fields; Jan/Feb roll into the next year
    always_comb
    begin
        wrap     = (s6_mix_reg >= sdcd_pkg::MIX_WRAP);
        day_full = s6_item_reg.doy
                 - sdcd_pkg::DOY_W'(sdcd_pkg::day_offset(s6_mix_reg));
        if (s6_item_reg.leap)
        begin
            year_next  = sdcd_pkg::LEAP_YEAR;
            month_next = sdcd_pkg::LEAP_MONTH;
            day_next   = sdcd_pkg::LEAP_DAY;
        end
        else
        begin
            year_next  = s6_item_reg.year_base + sdcd_pkg::YEAR_W'(wrap);
            month_next = s6_mix_reg + sdcd_pkg::MIX_START
                       - (wrap ? sdcd_pkg::MIX_YEAR : '0);
            day_next   = sdcd_pkg::DAY_W'(day_full);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s6_ready)
        begin
            s6_mix_reg  <= s6_mix_next;
            s6_item_reg <= in_item;
        end
        if (s6_valid_reg && s7_ready)
        begin
            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= day_next;
        end
    end

    assign out_valid = s7_valid_reg;
    assign year_out  = year_reg;
    assign month_out = month_reg;
    assign day_out   = day_reg;

endmodule

/* sv/serial_day_to_calendar_date.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_day_to_calendar_date
// Spreadsheet serial day number to Gregorian year, month and day.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, serial_day) takes one serial day per
//   transfer; output channel (out_valid/out_ready, year_out, month_out,
//   day_out) returns one date per transfer, in input order.
//   cfg_we/cfg_wdata write calendar_mode (0: 1900 base, 1: 1904 base, which
//   adds 1462 days). Write it only while no transfer is in flight.
//   Serial 60 in the 1900 base gives 29 Feb 1900; lower serials shift by one.
//   Seven register stages lie between input transfer and out_valid,
//   three of which each hold one reciprocal multiplier.
//   Throughput is one transfer per cycle while out_ready stays high.
//   Each stage has its own valid bit and loads when empty or when the next
//   stage moves, so a stalled receiver holds the output and the pipeline
//   keeps filling its empty stages; nothing is dropped or repeated.
//   Reset clears all valid bits and sets calendar_mode to the 1900 base.
// ----------------------------------------------------------------------------
module serial_day_to_calendar_date (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [sdcd_pkg::SERIAL_W-1:0] serial_day,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sdcd_pkg::YEAR_W-1:0]   year_out,
    output logic [sdcd_pkg::MONTH_W-1:0]  month_out,
    output logic [sdcd_pkg::DAY_W-1:0]    day_out
);

    logic                 calendar_mode_reg;
    logic                 cent_valid, cent_ready;
    sdcd_pkg::cent_item_t cent_item;
    logic                 year_valid, year_ready;
    sdcd_pkg::year_item_t year_item;

    // Mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calendar_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            calendar_mode_reg <= cfg_wdata;
        end
    end

    sdcd_cent u_cent (
        .clk           (clk),
        .rst_n         (rst_n),
        .calendar_mode (calendar_mode_reg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .serial_day    (serial_day),
        .out_valid     (cent_valid),
        .out_ready     (cent_ready),
        .out_item      (cent_item)
    );

    sdcd_year u_year (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cent_valid),
        .in_ready  (cent_ready),
        .in_item   (cent_item),
        .out_valid (year_valid),
        .out_ready (year_ready),
        .out_item  (year_item)
    );

    sdcd_mday u_mday (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (year_valid),
        .in_ready  (year_ready),
        .in_item   (year_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .year_out  (year_out),
        .month_out (month_out),
        .day_out   (day_out)
    );

    // An empty output stage lets the whole chain accept
    a_ready_when_drained: assert property (
        @(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready
    ) else $error("input stalled with an empty pipeline");

    // Month index stays in 1..12 for every serial
    a_month_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (month_out >= 4'd1 && month_out <= 4'd12)
    ) else $error("month out of range");

    // Day of month never zero
    a_day_nonzero: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (day_out != 5'd0)
    ) else $error("day of month is zero");

endmodule
